/* design/pab_pkg.sv */
// Shared types and constants for the palette alpha blender.
// No dependencies; used by the interfaces, the blend datapath and the top level.
`default_nettype none

package pab_pkg;

    localparam int RB_W      = 5;
    localparam int G_W       = 6;
    localparam int ALPHA_W   = 8;
    localparam int CHAN8_W   = 8;
    localparam int PIX_W     = 16;
    localparam int IDX_W     = 8;
    localparam int WORD_W    = 32;
    localparam int RB_SUM_W  = 13;
    localparam int G_SUM_W   = 14;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [RB_W-1:0]    src_r;
        logic [G_W-1:0]     src_g;
        logic [RB_W-1:0]    src_b;
        logic [RB_W-1:0]    dst_r;
        logic [G_W-1:0]     dst_g;
        logic [RB_W-1:0]    dst_b;
    } blend_in_t;

endpackage

`default_nettype wire

/* design/pab_req_if.sv */
// Request channel: palette loads and pixel beats into the blender.
// Depends on pab_pkg for field widths.
`default_nettype none

interface pab_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [pab_pkg::IDX_W-1:0]         entry_index;
    logic [pab_pkg::WORD_W-1:0]        palette_word;
    pab_pkg::pixel_t                   dest_pixel;

    modport source (output valid, req_type, entry_index, palette_word, dest_pixel,
                    input ready);
    modport sink   (input valid, req_type, entry_index, palette_word, dest_pixel,
                    output ready);
endinterface

`default_nettype wire

/* design/pab_pix_if.sv */
// Result channel: blended RGB565 pixel beats out of the blender.
// Depends on pab_pkg for the pixel type.
`default_nettype none

interface pab_pix_if;
    logic            valid;
    logic            ready;
    pab_pkg::pixel_t blended_pixel;

    modport source (output valid, blended_pixel, input ready);
    modport sink   (input valid, blended_pixel, output ready);
endinterface

`default_nettype wire

/* design/palette_alpha_blend_rgb565_top.sv */
// Palette overlay blender top level: palette RAM, lookup stage and blend pipeline.
// Depends on pab_pkg, pab_req_if, pab_pix_if, pab_ram and pab_blend.
//
// Usage:
//   req carries beats of two kinds. A load beat (req_type = REQ_LOAD) writes
//   palette_word into palette slot entry_index and yields no result; slots at or
//   beyond PALETTE_DEPTH are ignored. A pixel beat looks up entry_index, blends
//   the palette color over dest_pixel with the entry's alpha and yields one
//   RGB565 beat on pix. Indexes beyond the depth blend with alpha zero.
//   Pipeline: a pixel beat is registered as the RAM read at the accepting edge,
//   then as weighted sums, then as the divided and packed pixel on pix.
//   Throughput: one beat per clock while pix is not stalling, loads and pixels
//   mixed freely; a pixel may read a slot loaded by the beat just before it.
//   When pix stalls, the whole pipeline holds; req.ready drops only while the
//   output register is full and not being taken, so an empty output register
//   never blocks the input.
//   Reset clears the pipeline valid bits only; palette contents are undefined
//   until loaded, and no clearing pass runs.
`default_nettype none

module palette_alpha_blend_rgb565_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pab_req_if.sink    req,
    pab_pix_if.source  pix
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic                         en;
    logic                         accept;
    logic                         in_range;
    logic                         v1_reg, v2_reg, v3_reg;
    logic                         oob1_reg;
    pab_pkg::pixel_t              dst1_reg;
    logic [pab_pkg::WORD_W-1:0]   rdata;
    logic [pab_pkg::WORD_W-1:0]   entry;
    pab_pkg::blend_in_t           bin;

    assign en       = !v3_reg || pix.ready;
    assign req.ready = en;
    assign accept   = req.valid && en;
    assign in_range = {1'b0, req.entry_index} < (pab_pkg::IDX_W+1)'(PALETTE_DEPTH);

    pab_ram #(
        .WIDTH (pab_pkg::WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (accept && (req.req_type == pab_pkg::REQ_LOAD) && in_range),
        .waddr (req.entry_index[AW-1:0]),
        .wdata (req.palette_word),
        .re    (accept && (req.req_type == pab_pkg::REQ_PIXEL)),
        .raddr (req.entry_index[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept && (req.req_type == pab_pkg::REQ_PIXEL);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == pab_pkg::REQ_PIXEL))
        begin
            oob1_reg <= !in_range;
            dst1_reg <= req.dest_pixel;
        end
    end

    always_comb
    begin
        entry     = oob1_reg ? '0 : rdata;
        bin.alpha = entry[31:24];
        bin.src_r = entry[23:19];
        bin.src_g = entry[15:10];
        bin.src_b = entry[7:3];
        bin.dst_r = dst1_reg[15:11];
        bin.dst_g = dst1_reg[10:5];
        bin.dst_b = dst1_reg[4:0];
    end

    pab_blend u_blend (
        .clk (clk),
        .en  (en),
        .bin (bin),
        .pix (pix.blended_pixel)
    );

    assign pix.valid = v3_reg;

endmodule

`default_nettype wire

/* design/pab_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/pab_blend.sv */
// Two-stage blend datapath: weighted channel sums, then divide by 255 and pack.
// Depends on pab_pkg for blend_in_t and widths.
`default_nettype none

module pab_blend (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire pab_pkg::blend_in_t bin,
    output      pab_pkg::pixel_t    pix
);

    localparam int RBW = pab_pkg::RB_SUM_W;
    localparam int GW  = pab_pkg::G_SUM_W;

    logic [pab_pkg::ALPHA_W-1:0] inv_a;
    logic [RBW-1:0] r_sum_reg, r_sum_next;
    logic [GW-1:0]  g_sum_reg, g_sum_next;
    logic [RBW-1:0] b_sum_reg, b_sum_next;
    logic [RBW:0]   r_rnd;
    logic [GW:0]    g_rnd;
    logic [RBW:0]   b_rnd;
    pab_pkg::pixel_t pix_reg, pix_next;

    always_comb
    begin
        inv_a      = pab_pkg::ALPHA_MAX - bin.alpha;
        r_sum_next = RBW'(bin.dst_r) * RBW'(inv_a) + RBW'(bin.src_r) * RBW'(bin.alpha);
        g_sum_next = GW'(bin.dst_g) * GW'(inv_a) + GW'(bin.src_g) * GW'(bin.alpha);
        b_sum_next = RBW'(bin.dst_b) * RBW'(inv_a) + RBW'(bin.src_b) * RBW'(bin.alpha);
    end

    // x / 255 == (x + (x >> 8) + 1) >> 8 over the sum range
    always_comb
    begin
        r_rnd    = (RBW+1)'(r_sum_reg) + (RBW+1)'(r_sum_reg[RBW-1:8]) + (RBW+1)'(1);
        g_rnd    = (GW+1)'(g_sum_reg) + (GW+1)'(g_sum_reg[GW-1:8]) + (GW+1)'(1);
        b_rnd    = (RBW+1)'(b_sum_reg) + (RBW+1)'(b_sum_reg[RBW-1:8]) + (RBW+1)'(1);
        pix_next = {r_rnd[12:8], g_rnd[13:8], b_rnd[12:8]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
            pix_reg   <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

`default_nettype wire

/* test/palette_alpha_blend_rgb565_top_tb.sv */
// Self-checking testbench for palette_alpha_blend_rgb565_top: palette loads and pixel beats
// checked against a built-in blend predictor, with random idling and back-pressure.
// Depends on pab_pkg, pab_req_if, pab_pix_if and the top level.
`timescale 1ns / 100ps

module palette_alpha_blend_rgb565_top_tb;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                          kind;
        logic [pab_pkg::IDX_W-1:0]     idx;
        logic [pab_pkg::WORD_W-1:0]    word;
        pab_pkg::pixel_t               under;
        logic                          checked;
        pab_pkg::pixel_t               want;
    } blend_row_t;

    logic clk;
    logic rst_n;

    pab_req_if req_ch ();
    pab_pix_if pix_ch ();

    palette_alpha_blend_rgb565_top #(
        .PALETTE_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch)
    );

    logic [pab_pkg::WORD_W-1:0] palette_shadow [0:255];
    bit                         loaded [0:255];
    int                         loaded_slots [$];
    pab_pkg::pixel_t            expected_pixels [$];
    pab_pkg::pixel_t            predicted;
    pab_pkg::pixel_t            oldest;
    logic                       row_checked;
    pab_pkg::pixel_t            row_want;
    int                         src_idle_pct;
    int                         sink_idle_pct;
    int                         hold_left;
    int                         mismatches;
    int                         cycle_count;

    blend_row_t directed_rows [24] = '{
        '{pab_pkg::REQ_LOAD,  8'd0,   32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd0,   32'h0000_0000, 16'hFFFF, 1'b1, 16'hFFFF},
        '{pab_pkg::REQ_LOAD,  8'd255, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd255, 32'h0000_0000, 16'h1234, 1'b1, 16'hFFFF},
        '{pab_pkg::REQ_LOAD,  8'd1,   32'hFF00_0000, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd1,   32'h0000_0000, 16'hFFFF, 1'b1, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd2,   32'h00FF_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd2,   32'h0000_0000, 16'hA5A5, 1'b1, 16'hA5A5},
        '{pab_pkg::REQ_LOAD,  8'd223, 32'h80F8_0000, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd223, 32'h0000_0000, 16'h07FF, 1'b0, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd3,   32'hFF12_3456, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd3,   32'h0000_0000, 16'h0000, 1'b1, 16'h11AA},
        '{pab_pkg::REQ_LOAD,  8'd4,   32'h7FFF_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd4,   32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd5,   32'h0100_0000, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd5,   32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd128, 32'hAAAA_AAAA, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd128, 32'h0000_0000, 16'h5555, 1'b0, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd85,  32'h5555_5555, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd85,  32'h0000_0000, 16'hAAAA, 1'b0, 16'h0000},
        '{pab_pkg::REQ_LOAD,  8'd0,   32'hFEFF_00FF, 16'h0000, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd0,   32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000},
        '{pab_pkg::REQ_PIXEL, 8'd255, 32'h0000_0000, 16'h0000, 1'b1, 16'hFFFF},
        '{pab_pkg::REQ_PIXEL, 8'd1,   32'h0000_0000, 16'h0000, 1'b1, 16'h0000}
    };

    function automatic pab_pkg::pixel_t blend_rgb565(input logic [pab_pkg::WORD_W-1:0] entry,
                                                     input pab_pkg::pixel_t under);
        int unsigned a, amax, sr, sg, sb, dr, dg, db, r, g, b;
        amax = pab_pkg::ALPHA_MAX;
        a  = entry[31:24];
        sr = entry[23:19];
        sg = entry[15:10];
        sb = entry[7:3];
        dr = under[15:11];
        dg = under[10:5];
        db = under[4:0];
        r  = (dr * (amax - a) + sr * a) / amax;
        g  = (dg * (amax - a) + sg * a) / amax;
        b  = (db * (amax - a) + sb * a) / amax;
        return {r[pab_pkg::RB_W-1:0], g[pab_pkg::G_W-1:0], b[pab_pkg::RB_W-1:0]};
    endfunction

    task automatic report_mismatch(input string what, input pab_pkg::pixel_t got,
                                   input pab_pkg::pixel_t want);
        $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic offer_request(input logic kind, input logic [pab_pkg::IDX_W-1:0] idx,
                                 input logic [pab_pkg::WORD_W-1:0] word,
                                 input pab_pkg::pixel_t under,
                                 input logic checked, input pab_pkg::pixel_t want);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= 1'($urandom_range(1));
            req_ch.entry_index  <= pab_pkg::IDX_W'($urandom_range(255));
            req_ch.palette_word <= $urandom;
            req_ch.dest_pixel   <= pab_pkg::PIX_W'($urandom_range(16'hFFFF));
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.entry_index  <= idx;
        req_ch.palette_word <= word;
        req_ch.dest_pixel   <= under;
        row_checked = checked;
        row_want    = want;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == pab_pkg::REQ_LOAD && idx < DEPTH && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_slots.push_back(idx);
        end
    endtask

    task automatic offer_random(input int count);
        logic [pab_pkg::IDX_W-1:0]  idx;
        logic [pab_pkg::WORD_W-1:0] word;
        int                         pick;
        repeat (count)
        begin
            word = $urandom;
            pick = $urandom_range(3);
            if (pick == 0)
                word[31:24] = 8'h00;
            else if (pick == 1)
                word[31:24] = pab_pkg::ALPHA_MAX;
            if (loaded_slots.size() == 0 || $urandom_range(99) < 30)
            begin
                idx = (DEPTH < 256 && $urandom_range(9) == 0)
                    ? pab_pkg::IDX_W'($urandom_range(255, DEPTH))
                    : pab_pkg::IDX_W'($urandom_range(DEPTH - 1));
                offer_request(pab_pkg::REQ_LOAD, idx, word,
                              pab_pkg::PIX_W'($urandom_range(16'hFFFF)), 1'b0, '0);
            end
            else
            begin
                idx = (DEPTH < 256 && $urandom_range(9) == 0)
                    ? pab_pkg::IDX_W'($urandom_range(255, DEPTH))
                    : pab_pkg::IDX_W'(loaded_slots[$urandom_range(loaded_slots.size() - 1)]);
                offer_request(pab_pkg::REQ_PIXEL, idx, $urandom,
                              pab_pkg::PIX_W'($urandom_range(16'hFFFF)), 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL palette_alpha_blend_rgb565_top");
            $finish;
        end
    end

    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end
            else
                pix_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (req_ch.req_type == pab_pkg::REQ_LOAD)
            begin
                if (req_ch.entry_index < DEPTH)
                    palette_shadow[req_ch.entry_index] = req_ch.palette_word;
            end
            else
            begin
                predicted = blend_rgb565(
                    (req_ch.entry_index < DEPTH) ? palette_shadow[req_ch.entry_index] : '0,
                    req_ch.dest_pixel);
                expected_pixels.push_back(row_checked ? row_want : predicted);
            end
        end
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected beat", pix_ch.blended_pixel, '0);
            else
            begin
                oldest = expected_pixels.pop_front();
                if (pix_ch.blended_pixel !== oldest)
                    report_mismatch("blended_pixel", pix_ch.blended_pixel, oldest);
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = pab_pkg::REQ_LOAD;
        req_ch.entry_index  = '0;
        req_ch.palette_word = '0;
        req_ch.dest_pixel   = '0;
        row_checked         = 1'b0;
        row_want            = '0;
        src_idle_pct        = 8;
        sink_idle_pct       = 8;
        hold_left           = 0;
        mismatches          = 0;
        cycle_count         = 0;
        foreach (palette_shadow[i])
        begin
            palette_shadow[i] = '0;
            loaded[i]         = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].word,
                          directed_rows[i].under, directed_rows[i].checked,
                          directed_rows[i].want);
        row_checked = 1'b0;

        offer_random(500);

        // stall the result side long enough to back the pipeline up into req
        hold_left = HOLD_CYCLES;
        offer_random(100);

        // drain completely before the no-idle stretch
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        offer_random(300);

        src_idle_pct  = 8;
        sink_idle_pct = 8;
        offer_random(400);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS palette_alpha_blend_rgb565_top");
        else
            $display("FAIL palette_alpha_blend_rgb565_top");
        $finish;
    end

endmodule

/* palette_alpha_blend_rgb565_top.f */
design/pab_pkg.sv
design/pab_req_if.sv
design/pab_pix_if.sv
design/pab_ram.sv
design/pab_blend.sv
design/palette_alpha_blend_rgb565_top.sv
test/palette_alpha_blend_rgb565_top_tb.sv
